[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds define SYNTH and get
// empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_SYNC(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

[hdl/dmcfs_pkg.sv]
// ----------------------------------------------------------------------------
// dmcfs_pkg
// Types and fixed constants of the dot matrix column flip sequencer.
// ----------------------------------------------------------------------------
package dmcfs_pkg;

  localparam int COL_W       = 6;
  localparam int CMP_W       = COL_W + 1;
  localparam int BITS_W      = 16;
  localparam int ROW_W       = 4;
  localparam int WITHIN_W    = 5;
  localparam int GROUP_W     = 2;
  localparam int LINE_W      = 3;
  localparam int GROUP_SIZE  = 7;
  localparam int GROUPS      = 4;
  localparam int SHIFT_W     = 32;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_USED_W  = 44;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

[hdl/dot_matrix_column_flip_sequencer.sv]
// ----------------------------------------------------------------------------
// dot_matrix_column_flip_sequencer
// Turns one column of dot states into a run of pulse commands, one per dot
// that has to flip, using a store of the last pattern written to each column.
// ----------------------------------------------------------------------------
// A column beat is taken in the idle state and the old pattern read from the
// column store is compared in the load state; then one command beat leaves
// per cycle while the output side keeps up, lowest row first. A new column
// is not taken until the last beat of the one before is in the output
// register. The pace is set by the single output register and the registered
// read of the column store. A column with nothing to drive goes from the load
// state straight back to idle, and a column number past the last panel is
// dropped without touching the store. The store needs no clearing pass after
// reset: a valid bit per column makes unwritten columns read as all dots cleared.
`include "assert_macros.svh"

module dot_matrix_column_flip_sequencer
  import dmcfs_pkg::*;
#(
  parameter int PANELS            = 2,
  parameter int COLUMNS_PER_PANEL = 28,
  parameter int ROWS              = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // column_index, column_bits
  input  logic                   in_tuser,   // force_all
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // panel, group_address, line_address, row, dot_on, shift_word, column_level
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int TOTAL  = PANELS * COLUMNS_PER_PANEL;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam logic [BITS_W-1:0] ROW_MASK =
    (ROWS >= BITS_W) ? {BITS_W{1'b1}} : BITS_W'((32'd1 << ROWS) - 32'd1);

  state_t state_r, state_nxt;

  logic [COL_W-1:0]  in_col;
  logic [BITS_W-1:0] in_bits;
  logic              in_fire;
  logic              in_range;
  logic [ADDR_W-1:0] mem_addr;

  logic [BITS_W-1:0] mem [TOTAL];
  logic [BITS_W-1:0] rd_data_r;
  logic              rd_valid_r;
  logic [TOTAL-1:0]  valid_r;

  logic [COL_W-1:0]  col_r;
  logic [BITS_W-1:0] bits_r;
  logic              force_r;
  logic [BITS_W-1:0] pend_r, pend_nxt;
  logic [BITS_W-1:0] pend_load;
  logic [BITS_W-1:0] pick;
  logic [BITS_W-1:0] pend_rest;
  logic [ROW_W-1:0]  pick_row;
  logic              pick_on;
  logic              beat_fire;

  logic [1:0]          panel_idx;
  logic [WITHIN_W-1:0] col_in_panel;
  logic [GROUP_W-1:0]  group_c;
  logic [LINE_W-1:0]   line_c;
  logic                panel_r;
  logic [GROUP_W-1:0]  group_r;
  logic [LINE_W-1:0]   line_r;

  logic               out_valid_r;
  logic               out_panel_r;
  logic [GROUP_W-1:0] out_group_r;
  logic [LINE_W-1:0]  out_line_r;
  logic [ROW_W-1:0]   out_row_r;
  logic               out_on_r;
  logic [SHIFT_W-1:0] out_shift_r;
  logic               out_last_r;

  assign in_col   = in_tdata[COL_W-1:0];
  assign in_bits  = in_tdata[COL_W +: BITS_W] & ROW_MASK;
  assign in_fire  = in_tvalid && in_tready;
  assign in_range = {1'b0, in_col} < CMP_W'(TOTAL);
  assign mem_addr = ADDR_W'({1'b0, in_col});

  // Column store: read-first, so the old pattern comes back while the new
  // one is written in the same cycle.
  always_ff @(posedge clk) begin
    if (in_fire && in_range) begin
      mem[mem_addr] <= in_bits;
      rd_data_r     <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else if (in_fire && in_range) begin
      valid_r[mem_addr] <= 1'b1;
      rd_valid_r        <= valid_r[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r   <= in_col;
      bits_r  <= in_bits;
      force_r <= in_tuser;
    end
  end

  always_comb begin
    panel_idx    = '0;
    col_in_panel = WITHIN_W'(col_r);
    for (int p = 1; p < PANELS; p++) begin
      if ({1'b0, col_r} >= CMP_W'(p * COLUMNS_PER_PANEL)) begin
        panel_idx    = 2'(p);
        col_in_panel = WITHIN_W'({1'b0, col_r} - CMP_W'(p * COLUMNS_PER_PANEL));
      end
    end
    group_c = '0;
    line_c  = LINE_W'(col_in_panel);
    for (int g = 1; g < GROUPS; g++) begin
      if (col_in_panel >= WITHIN_W'(g * GROUP_SIZE)) begin
        group_c = GROUP_W'(g);
        line_c  = LINE_W'(col_in_panel - WITHIN_W'(g * GROUP_SIZE));
      end
    end
  end

  assign pend_load = force_r ? ROW_MASK
                             : (bits_r ^ (rd_valid_r ? rd_data_r : '0)) & ROW_MASK;

  assign pick      = pend_r & (~pend_r + BITS_W'(1));
  assign pend_rest = pend_r & ~pick;
  assign pick_on   = |(pick & bits_r);

  always_comb begin
    pick_row = '0;
    for (int i = 0; i < BITS_W; i++) begin
      if (pick[i]) begin
        pick_row = pick_row | ROW_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_range) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = (pend_load == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (beat_fire && pend_rest == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    beat_fire = 1'b0;
    pend_nxt  = pend_r;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_LOAD: pend_nxt = pend_load;
      ST_EMIT: begin
        beat_fire = !out_valid_r || out_tready;
        if (beat_fire) begin
          pend_nxt = pend_rest;
        end
      end
      default: pend_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      panel_r <= panel_idx[0];
      group_r <= group_c;
      line_r  <= line_c + LINE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_fire) begin
      out_panel_r <= panel_r;
      out_group_r <= group_r;
      out_line_r  <= line_r;
      out_row_r   <= pick_row;
      out_on_r    <= pick_on;
      out_shift_r <= pick_on ? {{BITS_W{1'b0}}, pick} : {pick, {BITS_W{1'b0}}};
      out_last_r  <= (pend_rest == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, ~out_on_r, out_shift_r,
                       out_on_r, out_row_r, out_line_r, out_group_r, out_panel_r};

  `ASSERT_SYNC(a_emit_has_work, state_r == ST_EMIT |-> pend_r != '0, "emit state with no rows left")
  `ASSERT_SYNC(a_last_ends_column, beat_fire && pend_rest == '0 |=> state_r == ST_IDLE && out_last_r, "last beat did not end the column")
  `ASSERT_SYNC(a_accept_reads, in_fire && in_range |=> state_r == ST_LOAD, "accepted column did not read the store")
  `ASSERT_SYNC(a_shift_onehot, out_valid_r |-> $onehot(out_shift_r), "row driver word not one-hot")
  `ASSERT_NEVER(a_row_in_range, out_valid_r && out_row_r >= ROW_W'(ROWS - 1) + ROW_W'(1) && ROWS < BITS_W, "command for a row past the panel height")

endmodule
